// ===== rtl/bfh_pkg.sv =====
`default_nettype none
package bfh_pkg;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned ByteW = 8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_PROBE_ADDR,
    ST_PROBE_WAIT,
    ST_PROBE_CHK,
    ST_SET,
    ST_OUT
  } bfh_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_byte;
    logic       reduce_step;
    logic       clear_key;
    logic       probe_rd;
    logic       probe_chk;
    logic       set_wr;
    logic       idx_inc;
    logic       idx_clr;
    logic       out_load;
  } bfh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clr_busy;
    logic       reduce_done;
    logic       idx_last;
    logic       is_last;
    logic       do_set;
  } bfh_sts_t;
endpackage
`default_nettype wire

// ===== rtl/bfh_in_if.sv =====
`default_nettype none
interface bfh_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] key_byte;
  logic       key_last;
  modport source (output valid, action, key_byte, key_last, input ready);
  modport sink   (input valid, action, key_byte, key_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfh_out_if.sv =====
`default_nettype none
interface bfh_out_if;
  logic valid;
  logic ready;
  logic was_present;
  logic inserted;
  modport source (output valid, was_present, inserted, input ready);
  modport sink   (input valid, was_present, inserted, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfh_ctrl.sv =====
`default_nettype none
module bfh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_free,
  input  wire bfh_pkg::bfh_sts_t sts,
  output bfh_pkg::bfh_cmd_t  cmd,
  output logic               in_ready
);
  import bfh_pkg::*;

  bfh_state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:      if (!sts.clr_busy) state_nxt = ST_IDLE;
      ST_IDLE:       if (in_fire) state_nxt = ST_REDUCE;
      ST_REDUCE:     if (sts.reduce_done) state_nxt = sts.is_last ? ST_PROBE_ADDR : ST_IDLE;
      ST_PROBE_ADDR: state_nxt = ST_PROBE_WAIT;
      ST_PROBE_WAIT: state_nxt = ST_PROBE_CHK;
      ST_PROBE_CHK:  state_nxt = sts.idx_last ? ST_SET : ST_PROBE_ADDR;
      ST_SET:        if (!sts.do_set || sts.idx_last) state_nxt = ST_OUT;
      ST_OUT:        if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // drive commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: ;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_byte = in_fire;
        cmd.idx_clr = 1'b1;
      end
      ST_REDUCE:     cmd.reduce_step = 1'b1;
      ST_PROBE_ADDR: cmd.probe_rd = 1'b1;
      ST_PROBE_WAIT: ;
      ST_PROBE_CHK: begin
        cmd.probe_chk = 1'b1;
        cmd.idx_inc = !sts.idx_last;
        cmd.idx_clr = sts.idx_last;
      end
      ST_SET: begin
        cmd.set_wr = sts.do_set;
        cmd.idx_inc = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = out_free;
        cmd.clear_key = out_free;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/bfh_dp.sv =====
`default_nettype none
module bfh_dp #(
  parameter int unsigned MAX_BITS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [10:0]          cfg_wdata,
  input  wire logic                 in_action,
  input  wire logic [7:0]           in_key_byte,
  input  wire logic                 in_key_last,
  input  wire bfh_pkg::bfh_cmd_t    cmd,
  output bfh_pkg::bfh_sts_t         sts,
  output logic                      res_present,
  output logic                      res_inserted
);
  import bfh_pkg::*;

  localparam int unsigned AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  // hash values live below M <= MAX_BITS; one spare bit for sums
  localparam int unsigned HW = AW + 1;
  localparam int unsigned PW = 2 * HW + ByteW;

  logic [CfgW-1:0] size_r;
  logic [HW-1:0]   mod_w;
  logic [HW-1:0]   h_r [4];
  logic [HW-1:0]   p19_r, p7_r;
  logic [7:0]      first_r;
  logic            start_r, act_r, last_r;
  logic [PW-1:0]   acc_r [6];
  logic [PW-1:0]   red_w [6];
  logic [$clog2(PW+1)-1:0] sh_r;
  logic [1:0]      idx_r;
  logic            present_r;
  logic            mem [MAX_BITS];
  logic            rd_r;
  logic [AW-1:0]   addr_w;
  logic [AW-1:0]   clr_r;
  logic            clr_busy_r;

  // clamp the configured size
  always_comb begin
    if (size_r == '0) mod_w = HW'(1);
    else if ({21'd0, size_r} > 32'(MAX_BITS)) mod_w = HW'(MAX_BITS);
    else mod_w = HW'(size_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       size_r <= CfgW'(1024);
    else if (cfg_we)  size_r <= cfg_wdata;
  end

  // reduce six raw values by shift-and-subtract, one bit per cycle
  logic [PW-1:0] msh_w;
  assign msh_w = PW'(mod_w) << sh_r;
  assign sts.reduce_done = (sh_r == '0);

  always_comb begin
    for (int k = 0; k < 6; k++)
      red_w[k] = (acc_r[k] >= msh_w) ? acc_r[k] - msh_w : acc_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      h_r[0] <= '0; h_r[1] <= HW'(1); h_r[2] <= HW'(7); h_r[3] <= HW'(3);
      p19_r <= HW'(1); p7_r <= HW'(1); first_r <= '0;
      sh_r <= '0;
    end else if (cmd.load_byte) begin
      // form raw sums; operands are already below M
      acc_r[0] <= PW'(h_r[0]) + PW'(in_key_byte);
      acc_r[1] <= PW'(h_r[1]) + PW'(in_key_byte) * PW'(p19_r);
      acc_r[2] <= PW'(h_r[2]) * PW'(31) + PW'(in_key_byte);
      acc_r[3] <= (PW'(h_r[3]) << 3)
                + PW'(start_r ? in_key_byte : first_r) * PW'(p7_r);
      acc_r[4] <= PW'(p19_r) * PW'(19);
      acc_r[5] <= PW'(p7_r) * PW'(7);
      if (start_r) first_r <= in_key_byte;
      start_r <= 1'b0;
      act_r <= in_action;
      last_r <= in_key_last;
      sh_r <= ($bits(sh_r))'(PW - HW);
    end else if (cmd.reduce_step) begin
      for (int k = 0; k < 6; k++) acc_r[k] <= red_w[k];
      if (sh_r == '0) begin
        for (int k = 0; k < 4; k++) h_r[k] <= red_w[k][HW-1:0];
        p19_r <= red_w[4][HW-1:0];
        p7_r  <= red_w[5][HW-1:0];
      end else begin
        sh_r <= sh_r - 1'b1;
      end
    end else if (cmd.clear_key) begin
      start_r <= 1'b1;
      h_r[0] <= '0; h_r[1] <= HW'(1); h_r[2] <= HW'(7); h_r[3] <= HW'(3);
      p19_r <= HW'(1); p7_r <= HW'(1); first_r <= '0;
    end
  end

  // final hashes reduced again under the present size
  logic [HW-1:0] hsel_w;
  assign hsel_w = h_r[idx_r];
  assign addr_w = (hsel_w >= mod_w) ? AW'(hsel_w - mod_w) : AW'(hsel_w);
  assign sts.idx_last = (idx_r == 2'd3);
  assign sts.is_last = last_r;
  assign sts.do_set = act_r && !present_r;
  assign sts.clr_busy = clr_busy_r;

  // walk the store once after reset, one address per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_r == AW'(MAX_BITS - 1)) clr_busy_r <= 1'b0;
      clr_r <= clr_r + 1'b1;
    end
  end

  // store read and write
  always_ff @(posedge clk) begin
    if (cmd.probe_rd) rd_r <= mem[addr_w];
    if (clr_busy_r)       mem[clr_r] <= 1'b0;
    else if (cmd.set_wr)  mem[addr_w] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      present_r <= 1'b1;
    end else begin
      if (cmd.idx_clr && !cmd.probe_chk) present_r <= 1'b1;
      if (cmd.probe_chk && !rd_r) present_r <= 1'b0;
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  // hold result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_present  <= present_r;
      res_inserted <= act_r && !present_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bloom_filter_four_hash_core.sv =====
// channel | dir | handshake     | word
// in      | in  | valid/ready   | action, key_byte, key_last
// out     | out | valid/ready   | was_present, inserted
// cfg     | in  | we only       | table_size (11 bits)
// Each byte is accepted in the idle state and then goes through the bit-serial
// modulo reduction of the six running values; no new byte is taken meanwhile.
// A last byte adds four store probes (address, wait and check states), a set
// state that writes the four bits only for an insert, and an output state.
// Reset is synchronous; a clearing pass then zeroes the store.
// A result word waits in a register; a stalled output holds the controller.
`default_nettype none
module bloom_filter_four_hash_core #(
  parameter int unsigned MAX_BITS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  bfh_in_if.sink           in_ch,
  bfh_out_if.source        out_ch
);
  import bfh_pkg::*;

  bfh_cmd_t cmd;
  bfh_sts_t sts;
  logic     in_fire, out_free, ovld_r, pres_w, ins_w;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !ovld_r || out_ch.ready;

  bfh_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .in_ready(in_ch.ready)
  );

  bfh_dp #(.MAX_BITS(MAX_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_action(in_ch.action), .in_key_byte(in_ch.key_byte),
    .in_key_last(in_ch.key_last), .cmd, .sts,
    .res_present(pres_w), .res_inserted(ins_w)
  );

  // advance output valid
  always_ff @(posedge clk) begin
    if (!rst_n)            ovld_r <= 1'b0;
    else if (cmd.out_load) ovld_r <= 1'b1;
    else if (out_ch.ready) ovld_r <= 1'b0;
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.was_present = pres_w;
  assign out_ch.inserted    = ins_w;
endmodule
`default_nettype wire

// ===== rtl/bfh_checker.sv =====
`default_nettype none
module bfh_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic was_present,
  input wire logic inserted
);
  // an insert never reports a hit
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(was_present && inserted)) else $error("both flags");
  // no byte is taken on the cycle after one
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("back to back");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(was_present))
    else $error("dropped");
endmodule

bind bloom_filter_four_hash_core bfh_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .was_present(out_ch.was_present), .inserted(out_ch.inserted)
);
`default_nettype wire
